// ===== src/tsp_pkg.sv =====
// Shared types and constants for the tar stream header parser.
`default_nettype none
package tsp_pkg;

    localparam int BLOCK_BYTES_DEF = 512;
    localparam int RES_DEPTH       = 4;
    localparam int RES_PTR_W       = $clog2(RES_DEPTH);
    localparam int RES_CNT_W       = $clog2(RES_DEPTH + 1);

    // header field offsets within a block
    localparam int OFS_MODE     = 100;
    localparam int OFS_UID      = 108;
    localparam int OFS_GID      = 116;
    localparam int OFS_SIZE     = 124;
    localparam int OFS_MTIME    = 136;
    localparam int OFS_CHKSUM   = 148;
    localparam int OFS_TYPEFLAG = 156;

    // result kinds
    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_BODY  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // entry types
    localparam logic [2:0] ET_REGULAR  = 3'd0;
    localparam logic [2:0] ET_HARDLINK = 3'd1;
    localparam logic [2:0] ET_SYMLINK  = 3'd2;
    localparam logic [2:0] ET_DIR      = 3'd3;
    localparam logic [2:0] ET_OTHER    = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TRUNC    = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM = 2'd2;
    localparam logic [1:0] ERR_TYPEFLAG = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  entry_type;
        logic [35:0] entry_size;
        logic [23:0] entry_mode;
        logic [35:0] entry_mtime;
        logic [23:0] owner_id;
        logic [23:0] group_id;
        logic [7:0]  body_byte;
        logic        body_last;
        logic [1:0]  error_code;
        logic        result_last;
    } result_t;

    // up to two results produced by one archive byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage
`default_nettype wire

// ===== src/tsp_if.sv =====
// Handshake channels: archive byte input and parser result output.
`default_nettype none
interface tsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, data_byte, end_of_stream, input ready);
    modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface tsp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  entry_type;
    logic [35:0] entry_size;
    logic [23:0] entry_mode;
    logic [35:0] entry_mtime;
    logic [23:0] owner_id;
    logic [23:0] group_id;
    logic [7:0]  body_byte;
    logic        body_last;
    logic [1:0]  error_code;
    logic        result_last;

    modport source (output valid, kind, entry_type, entry_size, entry_mode, entry_mtime,
                    owner_id, group_id, body_byte, body_last, error_code, result_last,
                    input ready);
    modport sink (input valid, kind, entry_type, entry_size, entry_mode, entry_mtime,
                  owner_id, group_id, body_byte, body_last, error_code, result_last,
                  output ready);
endinterface
`default_nettype wire

// ===== src/tsp_parser.sv =====
// Per-byte header parse, checksum, body tracking and result generation.
`default_nettype none
module tsp_parser #(
    parameter int BLOCK_BYTES = tsp_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_stream,
    output tsp_pkg::push_t     push
);
    import tsp_pkg::*;

    localparam int OFF_W = $clog2(BLOCK_BYTES);
    localparam logic [OFF_W-1:0] OFF_LAST      = OFF_W'(BLOCK_BYTES - 1);
    localparam logic [OFF_W-1:0] O_MODE        = OFF_W'(OFS_MODE);
    localparam logic [OFF_W-1:0] O_UID         = OFF_W'(OFS_UID);
    localparam logic [OFF_W-1:0] O_GID         = OFF_W'(OFS_GID);
    localparam logic [OFF_W-1:0] O_SIZE        = OFF_W'(OFS_SIZE);
    localparam logic [OFF_W-1:0] O_MTIME       = OFF_W'(OFS_MTIME);
    localparam logic [OFF_W-1:0] O_CHKSUM      = OFF_W'(OFS_CHKSUM);
    localparam logic [OFF_W-1:0] O_TYPEFLAG    = OFF_W'(OFS_TYPEFLAG);

    typedef enum logic [2:0] {
        PH_HEADER, PH_BODY, PH_SKIP, PH_PAD, PH_DONE, PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        NUM_PAD, NUM_DIGITS, NUM_STOP
    } num_phase_t;

    phase_t           phase_reg, phase_next;
    num_phase_t       nphase_reg, nphase_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [16:0]      sum_reg, sum_next;
    logic             zero_reg, zero_next;
    logic [35:0]      accum_reg, accum_next;
    logic [23:0]      chksum_reg, chksum_next;
    logic [35:0]      size_reg, size_next;
    logic [23:0]      mode_reg, mode_next;
    logic [35:0]      mtime_reg, mtime_next;
    logic [23:0]      uid_reg, uid_next;
    logic [23:0]      gid_reg, gid_next;
    logic [7:0]       type_reg, type_next;
    logic [35:0]      remain_reg, remain_next;

    always_comb
    begin
        logic [OFF_W-1:0] off;
        logic [OFF_W-1:0] next_off;
        logic [35:0]      acc;
        num_phase_t       np;
        logic             start;
        logic             pax;
        logic             bad_type;
        logic [2:0]       et;
        logic [35:0]      rem_dec;
        logic             main_v;
        logic             eos_v;
        result_t          main_r;
        result_t          eos_r;

        off      = offset_reg;
        next_off = (off == OFF_LAST) ? '0 : off + OFF_W'(1);

        phase_next  = phase_reg;
        nphase_next = nphase_reg;
        offset_next = offset_reg;
        sum_next    = sum_reg;
        zero_next   = zero_reg;
        accum_next  = accum_reg;
        chksum_next = chksum_reg;
        size_next   = size_reg;
        mode_next   = mode_reg;
        mtime_next  = mtime_reg;
        uid_next    = uid_reg;
        gid_next    = gid_reg;
        type_next   = type_reg;
        remain_next = remain_reg;

        acc      = '0;
        np       = NUM_PAD;
        start    = 1'b0;
        pax      = 1'b0;
        bad_type = 1'b0;
        et       = ET_OTHER;
        rem_dec  = remain_reg;
        main_v   = 1'b0;
        eos_v    = 1'b0;
        main_r   = '0;
        eos_r    = '0;

        if (fire && (phase_reg == PH_HEADER || phase_reg == PH_BODY ||
                     phase_reg == PH_SKIP || phase_reg == PH_PAD))
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (data_byte != 8'd0)
                    begin
                        zero_next = 1'b0;
                    end
                    // checksum field counts as spaces
                    if (off >= O_CHKSUM && off < O_TYPEFLAG)
                    begin
                        sum_next = sum_reg + 17'h20;
                    end
                    else
                    begin
                        sum_next = sum_reg + {9'd0, data_byte};
                    end

                    if (off >= O_MODE && off < O_TYPEFLAG)
                    begin
                        start = (off == O_MODE) || (off == O_UID) || (off == O_GID) ||
                                (off == O_SIZE) || (off == O_MTIME) || (off == O_CHKSUM);
                        acc = start ? '0 : accum_reg;
                        np  = start ? NUM_PAD : nphase_reg;
                        if (np == NUM_PAD && (data_byte == 8'h20 || data_byte == 8'h00))
                        begin
                            np = NUM_PAD;
                        end
                        else if (np != NUM_STOP && data_byte[7:3] == 5'b00110)
                        begin
                            acc = {acc[32:0], data_byte[2:0]};
                            np  = NUM_DIGITS;
                        end
                        else
                        begin
                            np = NUM_STOP;
                        end
                        accum_next  = acc;
                        nphase_next = np;

                        if (off == O_UID - OFF_W'(1))
                        begin
                            mode_next = acc[23:0];
                        end
                        if (off == O_GID - OFF_W'(1))
                        begin
                            uid_next = acc[23:0];
                        end
                        if (off == O_SIZE - OFF_W'(1))
                        begin
                            gid_next = acc[23:0];
                        end
                        if (off == O_MTIME - OFF_W'(1))
                        begin
                            size_next = acc;
                        end
                        if (off == O_CHKSUM - OFF_W'(1))
                        begin
                            mtime_next = acc;
                        end
                        if (off == O_TYPEFLAG - OFF_W'(1))
                        begin
                            chksum_next = acc[23:0];
                        end
                    end

                    if (off == O_TYPEFLAG)
                    begin
                        type_next = data_byte;
                    end

                    if (off == OFF_LAST)
                    begin
                        case (type_reg) inside
                            8'h78, 8'h58:           begin pax = 1'b1; et = ET_OTHER; end
                            8'h00, 8'h30:           et = ET_REGULAR;
                            8'h31:                  et = ET_HARDLINK;
                            8'h32:                  et = ET_SYMLINK;
                            8'h35:                  et = ET_DIR;
                            8'h33, 8'h34, 8'h36, 8'h37: et = ET_OTHER;
                            default:                bad_type = 1'b1;
                        endcase

                        if (zero_next)
                        begin
                            main_v      = 1'b1;
                            main_r.kind = KIND_END;
                            phase_next  = PH_DONE;
                        end
                        else if ({7'd0, sum_next} != chksum_reg)
                        begin
                            main_v            = 1'b1;
                            main_r.kind       = KIND_ERROR;
                            main_r.error_code = ERR_CHECKSUM;
                            phase_next        = PH_ERROR;
                        end
                        else if (bad_type)
                        begin
                            main_v            = 1'b1;
                            main_r.kind       = KIND_ERROR;
                            main_r.error_code = ERR_TYPEFLAG;
                            phase_next        = PH_ERROR;
                        end
                        else
                        begin
                            if (!pax)
                            begin
                                main_v             = 1'b1;
                                main_r.kind        = KIND_ENTRY;
                                main_r.entry_type  = et;
                                main_r.entry_size  = size_reg;
                                main_r.entry_mode  = mode_reg;
                                main_r.entry_mtime = mtime_reg;
                                main_r.owner_id    = uid_reg;
                                main_r.group_id    = gid_reg;
                            end
                            remain_next = size_reg;
                            if (size_reg == '0)
                            begin
                                phase_next = PH_HEADER;
                            end
                            else if (!pax && et == ET_REGULAR)
                            begin
                                phase_next = PH_BODY;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end

                PH_BODY, PH_SKIP:
                begin
                    if (remain_reg != '0)
                    begin
                        rem_dec = remain_reg - 36'd1;
                    end
                    remain_next = rem_dec;
                    if (phase_reg == PH_BODY)
                    begin
                        main_v           = 1'b1;
                        main_r.kind      = KIND_BODY;
                        main_r.body_byte = data_byte;
                        main_r.body_last = (rem_dec == '0);
                    end
                    if (rem_dec == '0)
                    begin
                        phase_next = (next_off == '0) ? PH_HEADER : PH_PAD;
                    end
                end

                PH_PAD:
                begin
                    if (next_off == '0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end

                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            offset_next = next_off;
            if (next_off == '0)
            begin
                sum_next  = '0;
                zero_next = 1'b1;
            end

            if (end_of_stream && phase_next != PH_DONE && phase_next != PH_ERROR)
            begin
                eos_v = 1'b1;
                if (phase_next == PH_HEADER && zero_next)
                begin
                    eos_r.kind = KIND_END;
                    phase_next = PH_DONE;
                end
                else
                begin
                    eos_r.kind       = KIND_ERROR;
                    eos_r.error_code = ERR_TRUNC;
                    phase_next       = PH_ERROR;
                end
            end
        end

        eos_r.result_last = 1'b1;
        main_r.result_last = !eos_v;

        push.count  = {1'b0, main_v} + {1'b0, eos_v};
        push.first  = main_v ? main_r : eos_r;
        push.second = eos_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            nphase_reg <= NUM_PAD;
            offset_reg <= '0;
            sum_reg    <= '0;
            zero_reg   <= 1'b1;
            accum_reg  <= '0;
            chksum_reg <= '0;
            size_reg   <= '0;
            mode_reg   <= '0;
            mtime_reg  <= '0;
            uid_reg    <= '0;
            gid_reg    <= '0;
            type_reg   <= '0;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            nphase_reg <= nphase_next;
            offset_reg <= offset_next;
            sum_reg    <= sum_next;
            zero_reg   <= zero_next;
            accum_reg  <= accum_next;
            chksum_reg <= chksum_next;
            size_reg   <= size_next;
            mode_reg   <= mode_next;
            mtime_reg  <= mtime_next;
            uid_reg    <= uid_next;
            gid_reg    <= gid_next;
            type_reg   <= type_next;
            remain_reg <= remain_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/tsp_res_fifo.sv =====
// Result queue: takes up to two results per cycle, delivers one per cycle.
`default_nettype none
module tsp_res_fifo (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  tsp_pkg::push_t                  push,
    input  wire logic                       pop,
    output tsp_pkg::result_t                head,
    output logic                            not_empty,
    output logic [tsp_pkg::RES_CNT_W-1:0]   level
);
    import tsp_pkg::*;

    result_t               slot_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + RES_CNT_W'(push.count) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            slot_reg[wr_ptr_reg + RES_PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign level     = count_reg;

endmodule
`default_nettype wire

// ===== src/tar_stream_header_parser_core.sv =====
// Top level of the tar stream header parser.
// Accepts one archive byte per cycle and emits entry descriptors, regular-file body
// bytes, a clean end or an error. Each byte passes an input register, then the
// parser updates its state and writes zero, one or two results into a four-entry
// result queue, whose head is offered at the result port.
// Sustained rate is one byte per cycle while results are taken every cycle; a byte
// that yields two results (a descriptor or body byte plus an end or error) hands
// them to the single-result output port one after the other. Input stalls while
// the queue has fewer than two free entries. After a clean end or an error the
// block is silent until reset.
`default_nettype none
module tar_stream_header_parser_core #(
    parameter int BLOCK_BYTES = tsp_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tsp_byte_if.sink      archive,
    tsp_result_if.source  result
);
    import tsp_pkg::*;

    logic                 stage_valid_reg, stage_valid_next;
    logic [7:0]           stage_byte_reg;
    logic                 stage_eos_reg;
    logic                 room;
    logic                 fire;
    logic                 take;
    logic [RES_CNT_W-1:0] level;
    logic                 not_empty;
    push_t                push;
    result_t              head;

    assign room = (level <= RES_CNT_W'(RES_DEPTH - 2));
    assign fire = stage_valid_reg && room;
    assign archive.ready = !stage_valid_reg || room;
    assign take = archive.valid && archive.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_byte_reg <= archive.data_byte;
            stage_eos_reg  <= archive.end_of_stream;
        end
    end

    tsp_parser #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .data_byte     (stage_byte_reg),
        .end_of_stream (stage_eos_reg),
        .push          (push)
    );

    tsp_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (result.valid && result.ready),
        .head      (head),
        .not_empty (not_empty),
        .level     (level)
    );

    assign result.valid       = not_empty;
    assign result.kind        = head.kind;
    assign result.entry_type  = head.entry_type;
    assign result.entry_size  = head.entry_size;
    assign result.entry_mode  = head.entry_mode;
    assign result.entry_mtime = head.entry_mtime;
    assign result.owner_id    = head.owner_id;
    assign result.group_id    = head.group_id;
    assign result.body_byte   = head.body_byte;
    assign result.body_last   = head.body_last;
    assign result.error_code  = head.error_code;
    assign result.result_last = head.result_last;

endmodule
`default_nettype wire

// ===== src/tsp_checker.sv =====
// Port-level assertions for the tar stream header parser, bound to the top level.
`default_nettype none
module tsp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [1:0] res_kind,
    input wire logic [1:0] res_error_code,
    input wire logic       res_result_last
);
    import tsp_pkg::*;

    // a waiting result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // nothing follows a clean end or an error
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && (res_kind == KIND_END || res_kind == KIND_ERROR)
        |=> !res_valid)
        else $error("result after end or error");

    // end and error always close the results of their byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_END || res_kind == KIND_ERROR) |-> res_result_last)
        else $error("end or error without result_last");

    // error code present exactly on error results
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_kind == KIND_ERROR) == (res_error_code != ERR_NONE)))
        else $error("error code does not match kind");

endmodule

bind tar_stream_header_parser_core tsp_checker u_tsp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_kind        (result.kind),
    .res_error_code  (result.error_code),
    .res_result_last (result.result_last)
);
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for tar_stream_header_parser_core: random ustar archives vs. predictor.
module tb;
    import tsp_pkg::*;

    localparam int BLOCK_LAST = BLOCK_BYTES_DEF - 1;

    // typeflag characters
    localparam bit [7:0] TF_OLD_REG    = 8'h00;
    localparam bit [7:0] TF_REG        = "0";
    localparam bit [7:0] TF_HARDLINK   = "1";
    localparam bit [7:0] TF_SYMLINK    = "2";
    localparam bit [7:0] TF_CHAR       = "3";
    localparam bit [7:0] TF_BLOCK      = "4";
    localparam bit [7:0] TF_DIR        = "5";
    localparam bit [7:0] TF_FIFO       = "6";
    localparam bit [7:0] TF_CONTIG     = "7";
    localparam bit [7:0] TF_PAX        = "x";
    localparam bit [7:0] TF_PAX_GLOBAL = "X";

    typedef enum bit [2:0] {PH_HEADER, PH_BODY, PH_SKIP, PH_PAD, PH_DONE, PH_ERROR} parse_phase_e;
    typedef enum bit [1:0] {NUM_PAD, NUM_DIGITS, NUM_STOPPED} num_state_e;
    typedef enum bit [2:0] {
        FIN_ZERO_BLOCK, FIN_AT_BOUNDARY, FIN_PARTIAL_ZERO, FIN_CUT_HEADER,
        FIN_CUT_BODY, FIN_CUT_PAD, FIN_BAD_SUM, FIN_BAD_TYPE
    } finish_style_e;

    class archive_checker;
        parse_phase_e ph;
        bit [8:0]     blk_ofs;
        bit [16:0]    hdr_sum;
        bit           blk_zero;
        bit [35:0]    num_acc;
        num_state_e   num_st;
        bit [23:0]    chk_field;
        bit [35:0]    size_field;
        bit [35:0]    mtime_field;
        bit [23:0]    mode_field;
        bit [23:0]    uid_field;
        bit [23:0]    gid_field;
        bit [7:0]     type_char;
        bit [35:0]    body_left;
        result_t      step_out[$];
        result_t      pending_results[$];
        int           mismatches;

        function new();
            ph = PH_HEADER;
            blk_ofs = '0;
            hdr_sum = '0;
            blk_zero = 1'b1;
            num_acc = '0;
            num_st = NUM_PAD;
            chk_field = '0;
            size_field = '0;
            mtime_field = '0;
            mode_field = '0;
            uid_field = '0;
            gid_field = '0;
            type_char = '0;
            body_left = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function bit finished();
            return ph == PH_DONE || ph == PH_ERROR;
        endfunction

        function void emit_status(logic [1:0] k, logic [1:0] code);
            result_t r;
            r = '0;
            r.kind = k;
            r.error_code = code;
            step_out.push_back(r);
        endfunction

        function void scan_octal(int ofs, bit [7:0] b);
            if (ofs == OFS_MODE || ofs == OFS_UID || ofs == OFS_GID || ofs == OFS_SIZE ||
                ofs == OFS_MTIME || ofs == OFS_CHKSUM)
            begin
                num_acc = '0;
                num_st = NUM_PAD;
            end
            // leading spaces and NULs are skipped, the first non-digit ends the field
            if (!(num_st == NUM_PAD && (b == 8'h20 || b == 8'h00)))
            begin
                if (num_st != NUM_STOPPED && b >= "0" && b <= "7")
                begin
                    num_acc = (num_acc << 3) + 36'(b - 8'h30);
                    num_st = NUM_DIGITS;
                end
                else
                    num_st = NUM_STOPPED;
            end
            case (ofs)
                OFS_MODE + 7:    mode_field = num_acc[23:0];
                OFS_UID + 7:     uid_field = num_acc[23:0];
                OFS_GID + 7:     gid_field = num_acc[23:0];
                OFS_SIZE + 11:   size_field = num_acc;
                OFS_MTIME + 11:  mtime_field = num_acc;
                OFS_CHKSUM + 7:  chk_field = num_acc[23:0];
                default: ;
            endcase
        endfunction

        function void close_header();
            bit [2:0] et;
            bit       pax;
            result_t  r;
            if (blk_zero)
            begin
                emit_status(KIND_END, ERR_NONE);
                ph = PH_DONE;
                return;
            end
            if ({7'd0, hdr_sum} != chk_field)
            begin
                emit_status(KIND_ERROR, ERR_CHECKSUM);
                ph = PH_ERROR;
                return;
            end
            pax = 1'b0;
            et = ET_OTHER;
            case (type_char)
                TF_PAX, TF_PAX_GLOBAL:                  pax = 1'b1;
                TF_OLD_REG, TF_REG:                     et = ET_REGULAR;
                TF_HARDLINK:                            et = ET_HARDLINK;
                TF_SYMLINK:                             et = ET_SYMLINK;
                TF_DIR:                                 et = ET_DIR;
                TF_CHAR, TF_BLOCK, TF_FIFO, TF_CONTIG:  et = ET_OTHER;
                default:
                begin
                    emit_status(KIND_ERROR, ERR_TYPEFLAG);
                    ph = PH_ERROR;
                    return;
                end
            endcase
            if (!pax)
            begin
                r = '0;
                r.kind = KIND_ENTRY;
                r.entry_type = et;
                r.entry_size = size_field;
                r.entry_mode = mode_field;
                r.entry_mtime = mtime_field;
                r.owner_id = uid_field;
                r.group_id = gid_field;
                step_out.push_back(r);
            end
            body_left = size_field;
            if (body_left == 0)
                ph = PH_HEADER;
            else
                ph = (!pax && et == ET_REGULAR) ? PH_BODY : PH_SKIP;
        endfunction

        function void take_byte(bit [7:0] b, bit eos);
            bit [8:0] ofs;
            bit [8:0] nxt;
            result_t  r;
            if (finished())
                return;
            step_out.delete();
            ofs = blk_ofs;
            nxt = ofs + 9'd1;
            case (ph)
                PH_HEADER:
                begin
                    if (b != 0)
                        blk_zero = 1'b0;
                    hdr_sum = hdr_sum + ((ofs >= OFS_CHKSUM && ofs < OFS_CHKSUM + 8) ?
                                         17'h20 : {9'd0, b});
                    if (ofs >= OFS_MODE && ofs < OFS_CHKSUM + 8)
                        scan_octal(ofs, b);
                    if (ofs == OFS_TYPEFLAG)
                        type_char = b;
                    if (ofs == BLOCK_LAST)
                        close_header();
                end
                PH_BODY, PH_SKIP:
                begin
                    if (body_left != 0)
                        body_left--;
                    if (ph == PH_BODY)
                    begin
                        r = '0;
                        r.kind = KIND_BODY;
                        r.body_byte = b;
                        r.body_last = (body_left == 0);
                        step_out.push_back(r);
                    end
                    if (body_left == 0)
                        ph = (nxt == 0) ? PH_HEADER : PH_PAD;
                end
                default:
                begin
                    if (nxt == 0)
                        ph = PH_HEADER;
                end
            endcase
            blk_ofs = nxt;
            if (nxt == 0)
            begin
                hdr_sum = '0;
                blk_zero = 1'b1;
            end
            if (eos && !finished())
            begin
                if (ph == PH_HEADER && blk_zero)
                begin
                    emit_status(KIND_END, ERR_NONE);
                    ph = PH_DONE;
                end
                else
                begin
                    emit_status(KIND_ERROR, ERR_TRUNC);
                    ph = PH_ERROR;
                end
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].result_last = 1'b1;
            foreach (step_out[i])
                pending_results.push_back(step_out[i]);
        endfunction

        function void cmp(string field, logic [35:0] want, logic [35:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0d", got.kind);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            cmp("kind", want.kind, got.kind);
            cmp("entry_type", want.entry_type, got.entry_type);
            cmp("entry_size", want.entry_size, got.entry_size);
            cmp("entry_mode", want.entry_mode, got.entry_mode);
            cmp("entry_mtime", want.entry_mtime, got.entry_mtime);
            cmp("owner_id", want.owner_id, got.owner_id);
            cmp("group_id", want.group_id, got.group_id);
            cmp("body_byte", want.body_byte, got.body_byte);
            cmp("body_last", want.body_last, got.body_last);
            cmp("error_code", want.error_code, got.error_code);
            cmp("result_last", want.result_last, got.result_last);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tsp_byte_if   arc();
    tsp_result_if res();

    tar_stream_header_parser_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .archive(arc),
        .result (res)
    );

    archive_checker  book;
    bit [7:0]        hdr [BLOCK_BYTES_DEF];
    bit [7:0]        arch_q[$];
    int              pause_at;
    bit              in_steady;
    bit              out_steady;
    longint unsigned cycles = 0;
    longint unsigned cycle_limit = 64'd50_000_000;

    // stretches of zero wait alternate with random waits
    function automatic int pick_wait(inout bit steady);
        if ($urandom_range(0, 99) == 0)
            steady = !steady;
        return steady ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic int octal_len(bit [35:0] v);
        int n;
        n = 1;
        while (n < 12 && (v >> (3 * n)) != 0)
            n++;
        return n;
    endfunction

    function automatic void put_octal(int ofs, int len, bit [35:0] v);
        int       nd;
        int       lead;
        int       p;
        int       i;
        bit [7:0] t;
        if (v == 0 && $urandom_range(0, 4) == 0)
        begin
            // field made of padding only
            for (i = 0; i < len; i++)
                hdr[ofs + i] = $urandom_range(0, 1) ? 8'h20 : 8'h00;
            return;
        end
        nd = octal_len(v);
        if (nd < len && $urandom_range(0, 3) == 0)
            nd = $urandom_range(nd, len);
        lead = (nd < len && $urandom_range(0, 2) == 0) ? $urandom_range(0, len - nd) : 0;
        p = ofs;
        for (i = 0; i < lead; i++)
        begin
            hdr[p] = $urandom_range(0, 1) ? 8'h20 : 8'h00;
            p++;
        end
        for (i = nd - 1; i >= 0; i--)
        begin
            hdr[p] = 8'h30 + 8'((v >> (3 * i)) & 36'd7);
            p++;
        end
        if (p < ofs + len)
        begin
            case ($urandom_range(0, 2))
                0: t = 8'h00;
                1: t = 8'h20;
                default:
                begin
                    t = 8'($urandom_range(0, 255));
                    while (t >= "0" && t <= "7")
                        t = 8'($urandom_range(0, 255));
                end
            endcase
            hdr[p] = t;
            p++;
            // anything after the terminator is ignored by the parser
            while (p < ofs + len)
            begin
                hdr[p] = 8'($urandom_range(0, 255));
                p++;
            end
        end
    endfunction

    function automatic void make_header(bit [7:0] tflag, bit [35:0] size, bit [23:0] mode,
                                        bit [23:0] uid, bit [23:0] gid, bit [35:0] mtime,
                                        bit bad_sum);
        int        i;
        bit        sparse;
        bit [16:0] sum;
        sparse = $urandom_range(0, 1);
        for (i = 0; i < BLOCK_BYTES_DEF; i++)
            hdr[i] = (i >= 100 && sparse) ? 8'h00 : 8'($urandom_range(0, 255));
        hdr[0] = 8'($urandom_range(1, 255));
        put_octal(OFS_MODE, 8, mode);
        put_octal(OFS_UID, 8, uid);
        put_octal(OFS_GID, 8, gid);
        put_octal(OFS_SIZE, 12, size);
        put_octal(OFS_MTIME, 12, mtime);
        hdr[OFS_TYPEFLAG] = tflag;
        sum = '0;
        for (i = 0; i < BLOCK_BYTES_DEF; i++)
            sum = sum + ((i >= OFS_CHKSUM && i < OFS_CHKSUM + 8) ? 17'h20 : {9'd0, hdr[i]});
        if (!bad_sum)
            put_octal(OFS_CHKSUM, 8, sum);
        else
        begin
            case ($urandom_range(0, 2))
                0: put_octal(OFS_CHKSUM, 8, 36'(sum) + 36'($urandom_range(1, 1000)));
                1: put_octal(OFS_CHKSUM, 8, 36'hFFFFFF);
                default: put_octal(OFS_CHKSUM, 8, 36'd0);
            endcase
        end
    endfunction

    function automatic void push_header(int count);
        int i;
        for (i = 0; i < count; i++)
            arch_q.push_back(hdr[i]);
    endfunction

    // fill < 0 gives random content
    function automatic void push_body(int size, int fill);
        int i;
        int pad;
        for (i = 0; i < size; i++)
            arch_q.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
        pad = (BLOCK_BYTES_DEF - size % BLOCK_BYTES_DEF) % BLOCK_BYTES_DEF;
        for (i = 0; i < pad; i++)
            arch_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_entry(bit [7:0] tflag, int size, bit [23:0] mode,
                                      bit [23:0] uid, bit [23:0] gid, bit [35:0] mtime,
                                      int fill);
        make_header(tflag, 36'(size), mode, uid, gid, mtime, 1'b0);
        push_header(BLOCK_BYTES_DEF);
        push_body(size, fill);
    endfunction

    function automatic bit [7:0] pick_type();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: return TF_REG;
            8, 9:   return TF_OLD_REG;
            10:     return TF_HARDLINK;
            11:     return TF_SYMLINK;
            12, 13: return TF_DIR;
            14:     return TF_CHAR;
            15:     return TF_BLOCK;
            16:     return TF_FIFO;
            17:     return TF_CONTIG;
            18:     return TF_PAX;
            default: return TF_PAX_GLOBAL;
        endcase
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 65)
            return $urandom_range(1, 40);
        if (r < 92)
            return $urandom_range(41, 600);
        if (r < 95)
            return BLOCK_BYTES_DEF;
        return $urandom_range(1000, 1600);
    endfunction

    function automatic void add_random_entry(int size);
        add_entry(pick_type(), size, 24'($urandom), 24'($urandom), 24'($urandom),
                  36'({$urandom, $urandom}), -1);
    endfunction

    function automatic void add_ending();
        finish_style_e fin;
        bit [7:0]      t;
        int            n;
        int            i;
        fin = finish_style_e'($urandom_range(0, 7));
        case (fin)
            FIN_ZERO_BLOCK:
            begin
                for (i = 0; i < 2 * BLOCK_BYTES_DEF; i++)
                    arch_q.push_back(8'h00);
            end
            FIN_AT_BOUNDARY:
            begin
                // stream stops right after an entry, often on a byte that has a result
                case ($urandom_range(0, 2))
                    0: add_random_entry(0);
                    1: add_entry(TF_REG, BLOCK_BYTES_DEF, 24'($urandom), 24'($urandom),
                                 24'($urandom), 36'({$urandom, $urandom}), -1);
                    default: add_random_entry(pick_size());
                endcase
            end
            FIN_PARTIAL_ZERO:
            begin
                n = $urandom_range(1, BLOCK_LAST);
                for (i = 0; i < n; i++)
                    arch_q.push_back(8'h00);
            end
            FIN_CUT_HEADER:
            begin
                make_header(TF_REG, 36'(pick_size() + 1), 24'($urandom), 24'($urandom),
                            24'($urandom), 36'({$urandom, $urandom}), 1'b0);
                push_header($urandom_range(0, 3) == 0 ? BLOCK_BYTES_DEF :
                            $urandom_range(1, BLOCK_LAST));
            end
            FIN_CUT_BODY:
            begin
                t = $urandom_range(0, 2) == 0 ? TF_DIR : TF_REG;
                make_header(t, $urandom_range(0, 1) ? 36'hFFFFFFFFF : 36'($urandom) | 36'h1000,
                            24'($urandom), 24'($urandom), 24'($urandom),
                            36'({$urandom, $urandom}), 1'b0);
                push_header(BLOCK_BYTES_DEF);
                n = $urandom_range(1, 700);
                for (i = 0; i < n; i++)
                    arch_q.push_back(8'($urandom_range(0, 255)));
            end
            FIN_CUT_PAD:
            begin
                n = $urandom_range(1, 500);
                make_header(TF_REG, 36'(n), 24'($urandom), 24'($urandom), 24'($urandom),
                            36'({$urandom, $urandom}), 1'b0);
                push_header(BLOCK_BYTES_DEF);
                for (i = 0; i < n; i++)
                    arch_q.push_back(8'($urandom_range(0, 255)));
                n = $urandom_range(0, BLOCK_LAST - n);
                for (i = 0; i < n; i++)
                    arch_q.push_back(8'($urandom_range(0, 255)));
            end
            FIN_BAD_SUM:
            begin
                make_header(pick_type(), 36'(pick_size()), 24'($urandom), 24'($urandom),
                            24'($urandom), 36'({$urandom, $urandom}), 1'b1);
                push_header(BLOCK_BYTES_DEF);
            end
            default:
            begin
                t = 8'($urandom_range(0, 255));
                while (t inside {TF_OLD_REG, TF_REG, TF_HARDLINK, TF_SYMLINK, TF_CHAR,
                                 TF_BLOCK, TF_DIR, TF_FIFO, TF_CONTIG, TF_PAX, TF_PAX_GLOBAL})
                    t = 8'($urandom_range(0, 255));
                make_header(t, 36'(pick_size()), 24'($urandom), 24'($urandom), 24'($urandom),
                            36'({$urandom, $urandom}), 1'b0);
                push_header(BLOCK_BYTES_DEF);
            end
        endcase
    endfunction

    function automatic void build_archive();
        int i;
        // directed entries: every typeflag, body sizes around a block, field extremes
        add_entry(TF_REG, 0, 24'd0, 24'd0, 24'd0, 36'd0, -1);
        add_entry(TF_OLD_REG, 1, 24'($urandom), 24'($urandom), 24'($urandom),
                  36'({$urandom, $urandom}), 8'hFF);
        add_entry(TF_REG, BLOCK_LAST, 24'($urandom), 24'd0, 24'($urandom), 36'd0, 8'h00);
        add_entry(TF_REG, BLOCK_BYTES_DEF, 24'o644, 24'd1000, 24'd1000, 36'o14000000000, -1);
        add_entry(TF_REG, BLOCK_BYTES_DEF + 1, 24'($urandom), 24'($urandom), 24'($urandom),
                  36'({$urandom, $urandom}), -1);
        add_entry(TF_HARDLINK, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 36'hFFFFFFFFF, -1);
        add_entry(TF_SYMLINK, 10, 24'o777, 24'd0, 24'd0, 36'd1, -1);
        add_entry(TF_CHAR, 0, 24'($urandom), 24'($urandom), 24'($urandom), 36'd7, -1);
        add_entry(TF_BLOCK, 3, 24'($urandom), 24'($urandom), 24'($urandom), 36'd8, -1);
        add_entry(TF_DIR, 0, 24'o755, 24'($urandom), 24'($urandom), 36'($urandom), -1);
        add_entry(TF_FIFO, 600, 24'($urandom), 24'($urandom), 24'($urandom), 36'd0, -1);
        add_entry(TF_CONTIG, 20, 24'($urandom), 24'($urandom), 24'($urandom), 36'd0, -1);
        add_entry(TF_PAX, 100, 24'($urandom), 24'($urandom), 24'($urandom), 36'd0, -1);
        add_entry(TF_PAX_GLOBAL, 0, 24'($urandom), 24'($urandom), 24'($urandom), 36'd0, -1);
        add_entry(TF_REG, 5, 24'($urandom), 24'($urandom), 24'($urandom), 36'd0, -1);
        pause_at = arch_q.size();
        for (i = 0; i < 20; i++)
            add_random_entry(pick_size());
        add_ending();
    endfunction

    task automatic drive_archive();
        int i;
        int gap;
        for (i = 0; i < arch_q.size() && !book.finished(); i++)
        begin
            if (i == pause_at)
            begin
                // hold off until the result side has fully drained
                arc.valid = 1'b0;
                while (book.pending() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            gap = pick_wait(in_steady);
            if (gap > 0)
            begin
                arc.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            arc.valid = 1'b1;
            arc.data_byte = arch_q[i];
            arc.end_of_stream = (i == arch_q.size() - 1);
            do
                @(posedge clk);
            while (!arc.ready);
            @(negedge clk);
        end
        arc.valid = 1'b0;
        arc.end_of_stream = 1'b0;
    endtask

    task automatic drain_results();
        int n;
        forever
        begin
            n = pick_wait(out_steady);
            if (n > 0)
            begin
                res.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            res.ready = 1'b1;
            do
                @(posedge clk);
            while (!res.valid);
            @(negedge clk);
        end
    endtask

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > cycle_limit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin : watch
        result_t got;
        if (rst_n === 1'b1)
        begin
            if (arc.valid && arc.ready)
                book.take_byte(arc.data_byte, arc.end_of_stream);
            if (res.valid && res.ready)
            begin
                got.kind = res.kind;
                got.entry_type = res.entry_type;
                got.entry_size = res.entry_size;
                got.entry_mode = res.entry_mode;
                got.entry_mtime = res.entry_mtime;
                got.owner_id = res.owner_id;
                got.group_id = res.group_id;
                got.body_byte = res.body_byte;
                got.body_last = res.body_last;
                got.error_code = res.error_code;
                got.result_last = res.result_last;
                book.check_result(got);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        arc.valid = 1'b0;
        arc.data_byte = 8'h00;
        arc.end_of_stream = 1'b0;
        res.ready = 1'b0;
        in_steady = 1'b0;
        out_steady = 1'b0;
        book = new();
        build_archive();
        // worst case per byte: full input wait plus two fully stalled results
        cycle_limit = 64'(arch_q.size()) * 84 + 50_000;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        fork
            drain_results();
        join_none
        drive_archive();
        while (book.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (book.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
src/tsp_pkg.sv
src/tsp_if.sv
src/tsp_parser.sv
src/tsp_res_fifo.sv
src/tar_stream_header_parser_core.sv
src/tsp_checker.sv
verif/tb.sv
